### rtl/core/xcfd_pkg.sv
package xcfd_pkg;

	localparam int BYTE_W = 8;

	// reset value of the start marker register
	localparam logic [BYTE_W-1:0] MARKER_RST = 8'hAA;

	// slots of the emitted frame ahead of the payload
	localparam int EMIT_MARK = 0;
	localparam int EMIT_LEN  = 1;
	localparam int EMIT_TYPE = 2;
	localparam int EMIT_PAY  = 3;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_BODY = 3'd3,
		PH_SUM  = 3'd4,
		PH_EMIT = 3'd5
	} phase_t;

	// control from the parser to the payload row
	typedef struct packed {
		logic              load;
		logic [BYTE_W-1:0] load_idx;
		logic              shift;
	} row_ctl_t;

endpackage

### rtl/core/xcfd_if.sv
interface xcfd_in_if;
	logic                       valid;
	logic                       ready;
	logic [xcfd_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface xcfd_out_if;
	logic                       valid;
	logic                       ready;
	logic [xcfd_pkg::BYTE_W-1:0] frame_byte;
	logic                       last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

### rtl/core/xcfd_cell.sv
module xcfd_cell (
	input  logic                        clk,
	input  logic                        load,
	input  logic [xcfd_pkg::BYTE_W-1:0] load_data,
	input  logic                        shift,
	input  logic [xcfd_pkg::BYTE_W-1:0] next_data,
	output logic [xcfd_pkg::BYTE_W-1:0] data
);
	import xcfd_pkg::*;

	logic [BYTE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;

endmodule

### rtl/core/xcfd_row.sv
module xcfd_row #(
	parameter int DEPTH = 60
) (
	input  logic                        clk,
	input  xcfd_pkg::row_ctl_t          ctl,
	input  logic [xcfd_pkg::BYTE_W-1:0] wr_data,
	output logic [xcfd_pkg::BYTE_W-1:0] head
);
	import xcfd_pkg::*;

	logic [BYTE_W-1:0] cell_data [DEPTH];

	// bytes are written at their own slot, then shifted out towards cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [BYTE_W-1:0] nxt;
		if (i == DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		xcfd_cell u_cell (
			.clk       (clk),
			.load      (ctl.load && (ctl.load_idx == BYTE_W'(i))),
			.load_data (wr_data),
			.shift     (ctl.shift),
			.next_data (nxt),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

### rtl/core/xor_checked_frame_deframer_core.sv
// Start/length/type frame deframer with XOR payload check.
// rx (sink): one serial byte per transfer. While hunting, bytes are dropped
//   until one equals the start marker; then length, type, payload, checksum.
// tx (source): the rebuilt frame (marker, length, type, payload, checksum),
//   one byte per transfer, last_byte set on the checksum. Bad or oversize
//   frames produce nothing.
// cfg_we/cfg_wdata: writes the start marker (reset 0xAA).
// Throughput: rx accepts a byte on every transfer while parsing. After a good
//   checksum transfer the frame is replayed from the payload cell row at up
//   to one byte per cycle: L+4 bytes for payload length L. rx is held off
//   (ready low) for the whole replay.
// Replay start: the checksum transfer moves the phase to replay, and the
//   output register then loads the first frame byte once it is free.
// Stall: tx output register holds its byte while ready is low; replay and
//   the cell row shift only when that register is free.
// Reset: hunting, marker 0xAA, no output pending. Cell row is not cleared.
module xor_checked_frame_deframer_core #(
	parameter int MAX_PAYLOAD = 60
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [xcfd_pkg::BYTE_W-1:0] cfg_wdata,
	xcfd_in_if.sink                     rx,
	xcfd_out_if.source                  tx
);
	import xcfd_pkg::*;

	// emit index runs 0 .. MAX_PAYLOAD+3
	localparam int IDXW = $clog2(MAX_PAYLOAD + 4);

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] marker_q;
	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] taken_q;
	logic [BYTE_W-1:0] xor_q;
	logic              over_q;
	logic [BYTE_W-1:0] chk_q;
	logic [IDXW-1:0]   emit_idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              in_fire;
	logic              out_free;
	logic              emit_step;
	logic              emit_last;
	logic              sum_ok;
	logic              body_done;
	logic [BYTE_W-1:0] emit_byte;
	logic [BYTE_W-1:0] row_head;
	row_ctl_t          row_ctl;

	assign rx.ready  = (phase_q != PH_EMIT);
	assign in_fire   = rx.valid && rx.ready;
	assign out_free  = !out_valid_q || tx.ready;
	assign emit_step = (phase_q == PH_EMIT) && out_free;
	assign emit_last = (emit_idx_q == (IDXW'(len_q) + IDXW'(EMIT_PAY)));
	assign sum_ok    = !over_q && (rx.rx_byte == xor_q);
	assign body_done = (({1'b0, taken_q} + 9'd1) >= {1'b0, len_q});

	// --- phase sequencing ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (in_fire) begin
			case (phase_q)
				PH_LEN:  phase_d = PH_TYPE;
				PH_TYPE: phase_d = (len_q == '0) ? PH_SUM : PH_BODY;
				PH_BODY: phase_d = body_done ? PH_SUM : PH_BODY;
				PH_SUM:  phase_d = sum_ok ? PH_EMIT : PH_IDLE;
				default: phase_d = (rx.rx_byte == marker_q) ? PH_LEN : PH_IDLE;
			endcase
		end else if (emit_step && emit_last) begin
			phase_d = PH_IDLE;
		end
	end

	// payload row: written at the byte count, shifted once per payload byte sent
	always_comb begin
		row_ctl.load     = in_fire && (phase_q == PH_BODY);
		row_ctl.load_idx = taken_q;
		row_ctl.shift    = emit_step && (emit_idx_q >= IDXW'(EMIT_PAY)) && !emit_last;
	end

	xcfd_row #(
		.DEPTH (MAX_PAYLOAD)
	) u_row (
		.clk     (clk),
		.ctl     (row_ctl),
		.wr_data (rx.rx_byte),
		.head    (row_head)
	);

	// --- parser registers ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RST;
			len_q    <= '0;
			type_q   <= '0;
			taken_q  <= '0;
			xor_q    <= '0;
			over_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				marker_q <= cfg_wdata;
			end
			if (in_fire) begin
				case (phase_q)
					PH_LEN: begin
						len_q   <= rx.rx_byte;
						over_q  <= (rx.rx_byte > BYTE_W'(MAX_PAYLOAD));
						taken_q <= '0;
						xor_q   <= '0;
					end
					PH_TYPE: begin
						type_q <= rx.rx_byte;
					end
					PH_BODY: begin
						xor_q   <= xor_q ^ rx.rx_byte;
						taken_q <= taken_q + BYTE_W'(1);
					end
					default: begin
						// checksum and hunt both leave the frame state cleared
						taken_q <= '0;
						xor_q   <= '0;
						over_q  <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (phase_q == PH_SUM)) begin
			chk_q <= rx.rx_byte;
		end
	end

	// --- replay and output register ---
	always_comb begin
		if (emit_idx_q == IDXW'(EMIT_MARK)) begin
			emit_byte = marker_q;
		end else if (emit_idx_q == IDXW'(EMIT_LEN)) begin
			emit_byte = len_q;
		end else if (emit_idx_q == IDXW'(EMIT_TYPE)) begin
			emit_byte = type_q;
		end else if (emit_last) begin
			emit_byte = chk_q;
		end else begin
			emit_byte = row_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				emit_idx_q <= '0;
			end else if (emit_step) begin
				emit_idx_q <= emit_idx_q + IDXW'(1);
			end
			if (emit_step) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	assign tx.valid      = out_valid_q;
	assign tx.frame_byte = out_byte_q;
	assign tx.last_byte  = out_last_q;

`ifndef NO_ASSERTIONS
	a_row_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(row_ctl.load && row_ctl.shift))
		else $error("payload row loaded and shifted in one cycle");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (taken_q < len_q))
		else $error("body phase with all payload bytes taken");

	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_step && emit_last) |=> (phase_q == PH_IDLE) && out_valid_q && out_last_q)
		else $error("frame replay did not end on the checksum byte");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMIT) |-> !over_q && (len_q <= BYTE_W'(MAX_PAYLOAD)))
		else $error("replay of an oversize frame");
`endif

endmodule
